// ===== src/tmr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tmr_pkg
// Shared types, constants and helpers of the tandem motif repeat detector.
// ============================================================================
package tmr_pkg;

    localparam int MAX_MOTIF_CHARS_DEFAULT = 16;
    localparam int MOTIF_REG_CHARS = 16;

    localparam int BASE_W = 8;
    localparam int LEN_W = 5;
    localparam int RUN_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_REPEATS = 2'd3;

    localparam logic [BASE_W-1:0] CHAR_A = 8'h41;
    localparam logic [BASE_W-1:0] CHAR_C = 8'h43;
    localparam logic [BASE_W-1:0] CHAR_G = 8'h47;
    localparam logic [BASE_W-1:0] CHAR_T = 8'h54;

    typedef struct packed {
        logic [MOTIF_REG_CHARS-1:0][BASE_W-1:0] motif;
        logic [LEN_W-1:0]                       len;
        logic [RUN_W-1:0]                       min_rep;
    } cfg_t;

    typedef struct packed {
        logic advance;
        logic first;
        logic last;
    } step_t;

    function automatic logic [BASE_W-1:0] complement(input logic [BASE_W-1:0] c);
        logic [BASE_W-1:0] r;
        case (c)
            CHAR_A:  r = CHAR_T;
            CHAR_T:  r = CHAR_A;
            CHAR_C:  r = CHAR_G;
            CHAR_G:  r = CHAR_C;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ===== src/tmr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tmr_cfg_regs
// Configuration register file: motif characters, motif length, repeat count.
// ============================================================================
module tmr_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tmr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output tmr_pkg::cfg_t                     cfg
);

    logic [tmr_pkg::CFG_DATA_W-1:0] motif_low_reg;
    logic [tmr_pkg::CFG_DATA_W-1:0] motif_high_reg;
    logic [tmr_pkg::LEN_W-1:0]      len_reg;
    logic [tmr_pkg::RUN_W-1:0]      min_rep_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motif_low_reg  <= '0;
            motif_high_reg <= '0;
            len_reg        <= '0;
            min_rep_reg    <= tmr_pkg::RUN_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                tmr_pkg::REG_MOTIF_LOW:    motif_low_reg  <= cfg_data;
                tmr_pkg::REG_MOTIF_HIGH:   motif_high_reg <= cfg_data;
                tmr_pkg::REG_MOTIF_LENGTH: len_reg        <= cfg_data[tmr_pkg::LEN_W-1:0];
                tmr_pkg::REG_MIN_REPEATS:  min_rep_reg    <= cfg_data[tmr_pkg::RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.motif   = {motif_high_reg, motif_low_reg};
    assign cfg.len     = len_reg;
    assign cfg.min_rep = min_rep_reg;

endmodule

// ===== src/tmr_window.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tmr_window
// Shift line of the newest characters, character count, and the parallel
// compare of the newest window against the motif and its reverse complement.
// ============================================================================
module tmr_window #(
    parameter int MAX_MOTIF_CHARS = tmr_pkg::MAX_MOTIF_CHARS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tmr_pkg::step_t                step,
    input  logic [tmr_pkg::BASE_W-1:0]    base,
    input  tmr_pkg::cfg_t                 cfg,
    output logic                          scan_en,
    output logic                          fwd_match,
    output logic                          rev_match
);

    localparam int CS_W = $clog2(MAX_MOTIF_CHARS + 1);
    localparam int LIMIT = (MAX_MOTIF_CHARS < tmr_pkg::MOTIF_REG_CHARS) ?
                           MAX_MOTIF_CHARS : tmr_pkg::MOTIF_REG_CHARS;

    logic [MAX_MOTIF_CHARS-1:0][tmr_pkg::BASE_W-1:0] recent_reg;
    logic [MAX_MOTIF_CHARS-1:0][tmr_pkg::BASE_W-1:0] recent_next;
    logic [CS_W-1:0]                                 seen_reg;
    logic [CS_W-1:0]                                 seen_eff;
    logic [CS_W-1:0]                                 seen_next;

    always_comb begin
        recent_next[0] = base;
        for (int i = 1; i < MAX_MOTIF_CHARS; i++) begin
            recent_next[i] = recent_reg[i-1];
        end
        seen_eff  = step.first ? '0 : seen_reg;
        seen_next = (seen_eff == CS_W'(MAX_MOTIF_CHARS)) ? seen_eff : seen_eff + 1'b1;
    end

    // Entries older than the character count are never compared, so the
    // shift line itself needs no clearing.
    always_ff @(posedge aclk) begin
        if (step.advance) begin
            recent_reg <= recent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (step.advance) begin
            seen_reg <= step.last ? '0 : seen_next;
        end
    end

    always_comb begin
        logic [tmr_pkg::LEN_W-1:0] idx;
        scan_en = (cfg.len != '0) && (cfg.len <= tmr_pkg::LEN_W'(LIMIT)) &&
                  (cfg.min_rep != '0) &&
                  ({{tmr_pkg::LEN_W{1'b0}}, seen_next} >= {{CS_W{1'b0}}, cfg.len});
        fwd_match = 1'b1;
        rev_match = 1'b1;
        for (int j = 0; j < LIMIT; j++) begin
            idx = cfg.len - 5'd1 - tmr_pkg::LEN_W'(j);
            if (tmr_pkg::LEN_W'(j) < cfg.len) begin
                if (recent_next[j] != cfg.motif[idx[3:0]]) begin
                    fwd_match = 1'b0;
                end
                if (recent_next[j] != tmr_pkg::complement(cfg.motif[j])) begin
                    rev_match = 1'b0;
                end
            end
        end
    end

endmodule

// ===== src/tmr_scan_ctr.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tmr_scan_ctr
// Greedy scan of one orientation: skip counter and saturating run counter.
// ============================================================================
module tmr_scan_ctr (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tmr_pkg::step_t                step,
    input  tmr_pkg::cfg_t                 cfg,
    input  logic                          scan_en,
    input  logic                          match,
    output logic                          hit
);

    logic [tmr_pkg::LEN_W-1:0] skip_reg;
    logic [tmr_pkg::LEN_W-1:0] skip_eff;
    logic [tmr_pkg::LEN_W-1:0] skip_next;
    logic [tmr_pkg::RUN_W-1:0] run_reg;
    logic [tmr_pkg::RUN_W-1:0] run_eff;
    logic [tmr_pkg::RUN_W-1:0] run_next;

    always_comb begin
        skip_eff  = step.first ? '0 : skip_reg;
        run_eff   = step.first ? '0 : run_reg;
        skip_next = skip_eff;
        run_next  = run_eff;
        hit       = 1'b0;
        if (scan_en) begin
            if (skip_eff != '0) begin
                skip_next = skip_eff - 1'b1;
            end else if (match) begin
                run_next  = (run_eff == '1) ? run_eff : run_eff + 1'b1;
                skip_next = cfg.len - 1'b1;
                hit       = (run_next >= cfg.min_rep);
            end else begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= '0;
            run_reg  <= '0;
        end else if (step.advance) begin
            skip_reg <= step.last ? '0 : skip_next;
            run_reg  <= step.last ? '0 : run_next;
        end
    end

endmodule

// ===== src/tandem_motif_repeat_detector.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tandem_motif_repeat_detector
// Scans an end region for back-to-back copies of a motif or its reverse
// complement and gives one verdict per region.
// ============================================================================
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  tdata base, tuser region/first, tlast
//  m_       out        m_tvalid/m_tready  tdata found, tuser result_region
//  cfg_     in         cfg_valid/ready    cfg_index, cfg_data
//
// One item per cycle unless a waiting result stalls it; an item is processed from the input register after it is
// accepted, and its verdict, if any, is shown from the result register in the cycle after that item is processed.
// The input register, the scan counters and the result register form the path.
// Reset clears the character count, scan counters, hit latch and valid flags, but not the shift line of characters;
// the configuration returns to its reset values. A waiting result stalls only an item that ends a region.
// ============================================================================
module tandem_motif_repeat_detector #(
    parameter int MAX_MOTIF_CHARS = tmr_pkg::MAX_MOTIF_CHARS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] base
    input  logic [1:0]                        s_tuser,   // [0] region, [1] first_in_region
    input  logic                              s_tlast,   // last_in_region
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [0] found, [7:1] zero
    output logic [0:0]                        m_tuser,   // [0] result_region
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tmr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tmr_pkg::cfg_t  cfg;
    tmr_pkg::step_t step;

    logic                       in_valid_reg;
    logic [tmr_pkg::BASE_W-1:0] base_reg;
    logic                       region_reg;
    logic                       first_reg;
    logic                       last_reg;
    logic                       hit_latched_reg;
    logic                       hit_latched_next;
    logic                       out_valid_reg;
    logic                       out_region_reg;
    logic                       out_found_reg;
    logic                       advance;
    logic                       scan_en;
    logic                       fwd_match;
    logic                       rev_match;
    logic                       fwd_hit;
    logic                       rev_hit;

    tmr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign step.advance = advance;
    assign step.first   = first_reg;
    assign step.last    = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            base_reg   <= s_tdata;
            region_reg <= s_tuser[0];
            first_reg  <= s_tuser[1];
            last_reg   <= s_tlast;
        end
    end

    tmr_window #(
        .MAX_MOTIF_CHARS (MAX_MOTIF_CHARS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .base      (base_reg),
        .cfg       (cfg),
        .scan_en   (scan_en),
        .fwd_match (fwd_match),
        .rev_match (rev_match)
    );

    tmr_scan_ctr u_fwd_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg),
        .scan_en (scan_en),
        .match   (fwd_match),
        .hit     (fwd_hit)
    );

    tmr_scan_ctr u_rev_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg),
        .scan_en (scan_en),
        .match   (rev_match),
        .hit     (rev_hit)
    );

    assign hit_latched_next = (hit_latched_reg && !first_reg) || fwd_hit || rev_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_latched_reg <= 1'b0;
        end else if (advance) begin
            hit_latched_reg <= last_reg ? 1'b0 : hit_latched_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_reg) begin
            out_region_reg <= region_reg;
            out_found_reg  <= hit_latched_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, out_found_reg};
    assign m_tuser[0] = out_region_reg;

`ifndef NO_ASSERTIONS
    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && last_reg |=> out_valid_reg)
        else $error("region end did not produce a result");

    a_hit_cleared_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && last_reg |=> !hit_latched_reg)
        else $error("hit latch survived the end of a region");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the tandem motif repeat detector.
// A directed pass covers the edge cases, such as an empty motif, a zero repeat
// count, a motif that is too long, a short region, a one-character region and
// a setting changed inside a region. Random regions follow, built mostly from
// tandem copies of the motif or of its reverse complement, under many register
// settings. A scan model inside the bench predicts every verdict. The sender
// works in bursts and the receiver stalls on its own pattern.
// ============================================================================
module tb;

    localparam int DEPTH = tmr_pkg::MAX_MOTIF_CHARS_DEFAULT;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic region;
        logic found;
    } verdict_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;     // [7:0] base
    logic [1:0]                     s_tuser = '0;     // [0] region, [1] first_in_region
    logic                           s_tlast = 1'b0;   // last_in_region
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;          // [0] found, [7:1] zero
    logic [0:0]                     m_tuser;          // [0] result_region
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tmr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tmr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    tandem_motif_repeat_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Scan model state.
    logic [tmr_pkg::MOTIF_REG_CHARS-1:0][tmr_pkg::BASE_W-1:0] cfg_motif = '0;
    logic [tmr_pkg::LEN_W-1:0] cfg_len = '0;
    logic [tmr_pkg::RUN_W-1:0] cfg_min = 8'd1;
    logic [tmr_pkg::BASE_W-1:0] recent_chars [DEPTH];
    logic [tmr_pkg::LEN_W-1:0] chars_seen;
    logic [tmr_pkg::LEN_W-1:0] fwd_skip, rev_skip;
    logic [tmr_pkg::RUN_W-1:0] fwd_run, rev_run;
    logic hit_seen;

    verdict_t pending_verdicts [$];

    int unsigned errors = 0;
    int unsigned chars_sent = 0;
    int unsigned regions_closed = 0;
    int unsigned verdicts_checked = 0;
    int unsigned verdicts_found = 0;
    int unsigned settings_applied = 0;
    int unsigned burst_left = 0;
    int unsigned hold_left = 0;

    function automatic logic [tmr_pkg::BASE_W-1:0] base_complement(
        input logic [tmr_pkg::BASE_W-1:0] c);
        case (c)
            tmr_pkg::CHAR_A: return tmr_pkg::CHAR_T;
            tmr_pkg::CHAR_T: return tmr_pkg::CHAR_A;
            tmr_pkg::CHAR_C: return tmr_pkg::CHAR_G;
            tmr_pkg::CHAR_G: return tmr_pkg::CHAR_C;
            default:         return c;
        endcase
    endfunction

    function automatic logic [tmr_pkg::BASE_W-1:0] random_nucleotide();
        case ($urandom_range(0, 3))
            0:       return tmr_pkg::CHAR_A;
            1:       return tmr_pkg::CHAR_C;
            2:       return tmr_pkg::CHAR_G;
            default: return tmr_pkg::CHAR_T;
        endcase
    endfunction

    function automatic logic [127:0] pack_motif(input string s);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < s.len() && i < 16; i++) m[i*8 +: 8] = s[i];
        return m;
    endfunction

    function automatic bit window_hit(input logic [tmr_pkg::LEN_W-1:0] n, input bit rev);
        logic [tmr_pkg::BASE_W-1:0] want;
        for (int k = 0; k < int'(n); k++) begin
            want = rev ? base_complement(cfg_motif[int'(n) - 1 - k]) : cfg_motif[k];
            if (recent_chars[int'(n) - 1 - k] != want) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_scan_state();
        for (int i = 0; i < DEPTH; i++) recent_chars[i] = '0;
        chars_seen = '0;
        fwd_skip = '0;
        rev_skip = '0;
        fwd_run = '0;
        rev_run = '0;
        hit_seen = 1'b0;
    endtask

    task automatic advance_scan(input bit rev, inout logic [tmr_pkg::LEN_W-1:0] skip,
                                inout logic [tmr_pkg::RUN_W-1:0] run);
        if (skip != 0) begin
            skip = skip - 1'b1;
        end else if (window_hit(cfg_len, rev)) begin
            if (run != 8'hFF) run = run + 1'b1;
            skip = cfg_len - 1'b1;
            if (run >= cfg_min) hit_seen = 1'b1;
        end else begin
            run = '0;
        end
    endtask

    task automatic predict_char(input logic [7:0] b, input logic rg, input logic is_first,
                                input logic is_last);
        verdict_t v;
        if (is_first) clear_scan_state();
        for (int i = DEPTH - 1; i > 0; i--) recent_chars[i] = recent_chars[i - 1];
        recent_chars[0] = b;
        if (chars_seen < DEPTH) chars_seen = chars_seen + 1'b1;
        if (cfg_len >= 1 && cfg_len <= tmr_pkg::MOTIF_REG_CHARS && cfg_len <= DEPTH &&
            cfg_min != 0 && chars_seen >= cfg_len) begin
            advance_scan(1'b0, fwd_skip, fwd_run);
            advance_scan(1'b1, rev_skip, rev_run);
        end
        if (is_last) begin
            v.region = rg;
            v.found = hit_seen;
            pending_verdicts.push_back(v);
            regions_closed++;
            clear_scan_state();
        end
    endtask

    // Receiver: ready stretches of random length, broken by short stalls.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            hold_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
            hold_left <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
        end
    end

    always @(posedge aclk) begin : verdict_check
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                if (errors < 10)
                    $display("%0t: unexpected verdict region=%0d tdata=%h", $realtime,
                             m_tuser[0], m_tdata);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (want.found) verdicts_found++;
                if (m_tdata !== {7'b0, want.found} || m_tuser[0] !== want.region) begin
                    if (errors < 10)
                        $display({"%0t: verdict mismatch: expected region=%0d found=%0d,",
                                  " got region=%0d tdata=%h"},
                                 $realtime, want.region, want.found, m_tuser[0], m_tdata);
                    errors++;
                end
            end
        end
    end

    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_char(input logic [7:0] b, input logic rg, input logic is_first,
                             input logic is_last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= {is_first, rg};
        s_tlast <= is_last;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
        predict_char(b, rg, is_first, is_last);
    endtask

    task automatic send_run(input logic [7:0] chars [$], input int lo, input int hi,
                            input logic rg, input bit with_first, input bit with_last);
        for (int i = lo; i <= hi; i++)
            send_char(chars[i], rg, with_first && i == lo, with_last && i == hi);
    endtask

    task automatic send_text(input string s, input logic rg, input bit with_first,
                             input bit with_last);
        logic [7:0] chars [$];
        for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
        send_run(chars, 0, chars.size() - 1, rg, with_first, with_last);
    endtask

    task automatic cfg_write(input logic [tmr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        drain_verdicts();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tmr_pkg::REG_MOTIF_LOW:    cfg_motif[7:0] = data;
            tmr_pkg::REG_MOTIF_HIGH:   cfg_motif[15:8] = data;
            tmr_pkg::REG_MOTIF_LENGTH: cfg_len = data[tmr_pkg::LEN_W-1:0];
            tmr_pkg::REG_MIN_REPEATS:  cfg_min = data[tmr_pkg::RUN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [127:0] m, input logic [4:0] n,
                              input logic [7:0] r);
        logic [63:0] d;
        cfg_write(tmr_pkg::REG_MOTIF_LOW, m[63:0]);
        cfg_write(tmr_pkg::REG_MOTIF_HIGH, m[127:64]);
        d = {$urandom, $urandom};
        d[4:0] = n;
        cfg_write(tmr_pkg::REG_MOTIF_LENGTH, d);
        d = {$urandom, $urandom};
        d[7:0] = r;
        cfg_write(tmr_pkg::REG_MIN_REPEATS, d);
        settings_applied++;
    endtask

    task automatic test_directed_cases();
        set_config(pack_motif("TAG"), 5'd3, 8'd2);
        send_text("TAGTAG", 1'b0, 1'b1, 1'b1);
        cfg_write(tmr_pkg::REG_MIN_REPEATS, 64'd1);
        send_text("CTA", 1'b1, 1'b1, 1'b1);
        send_text("TA", 1'b0, 1'b1, 1'b1);
        send_char(8'hFF, 1'b1, 1'b1, 1'b1);
        // The length is cleared inside a region that then ends without a new first flag.
        send_text("TA", 1'b1, 1'b1, 1'b0);
        cfg_write(tmr_pkg::REG_MOTIF_LENGTH, 64'd0);
        send_char(tmr_pkg::CHAR_G, 1'b1, 1'b0, 1'b1);
        cfg_write(tmr_pkg::REG_MOTIF_LENGTH, 64'd17);
        send_char(8'h00, 1'b0, 1'b1, 1'b0);
        send_text("TAG", 1'b0, 1'b0, 1'b1);
        cfg_write(tmr_pkg::REG_MOTIF_LENGTH, 64'd3);
        cfg_write(tmr_pkg::REG_MIN_REPEATS, 64'd0);
        send_text("TAG", 1'b1, 1'b1, 1'b1);
    endtask

    task automatic randomize_config(input int phase);
        logic [127:0] m;
        logic [4:0] n;
        logic [7:0] r;
        int unsigned pick;
        bit raw;
        raw = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < 16; i++) m[i*8 +: 8] = raw ? 8'($urandom) : random_nucleotide();
        pick = $urandom_range(0, 9);
        if (phase == 0) n = 5'd16;
        else if (phase == 1) n = 5'd1;
        else if (pick < 6) n = 5'($urandom_range(1, 6));
        else if (pick < 8) n = 5'($urandom_range(7, 16));
        else if (pick == 8) n = 5'd0;
        else n = 5'($urandom_range(17, 31));
        pick = $urandom_range(0, 19);
        if (phase == 0) r = 8'd2;
        else if (pick < 12) r = 8'($urandom_range(1, 3));
        else if (pick < 15) r = 8'($urandom_range(4, 6));
        else if (pick < 17) r = 8'd0;
        else if (pick < 19) r = 8'd255;
        else r = 8'($urandom);
        set_config(m, n, r);
    endtask

    task automatic send_random_region();
        logic [7:0] chars [$];
        int unsigned unit, copies, mode, split;
        bit rev, with_first, with_last;
        logic rg;
        unit = (cfg_len >= 1 && cfg_len <= 16) ? 32'(cfg_len) : $urandom_range(1, 6);
        mode = $urandom_range(0, 9);
        rg = 1'($urandom_range(0, 1));
        with_first = 1'b1;
        with_last = 1'b1;
        if (mode <= 6) begin
            repeat ($urandom_range(0, 3)) chars.push_back(random_nucleotide());
            copies = $urandom_range(0, (cfg_min > 3) ? 4 : int'(cfg_min) + 1);
            rev = 1'($urandom_range(0, 1));
            repeat (copies) begin
                for (int k = 0; k < int'(unit); k++)
                    chars.push_back(rev ? base_complement(cfg_motif[unit - 1 - k])
                                        : cfg_motif[k]);
                if ($urandom_range(0, 7) == 0)
                    chars[$urandom_range(0, chars.size() - 1)] = random_nucleotide();
            end
            repeat ($urandom_range(0, 2)) chars.push_back(random_nucleotide());
            if (chars.size() == 0) chars.push_back(random_nucleotide());
        end else if (mode <= 8) begin
            repeat ($urandom_range(1, 12)) chars.push_back(random_nucleotide());
        end else begin
            repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom));
        end
        if (mode == 6 || mode == 9) begin
            with_first = 1'($urandom_range(0, 1));
            with_last = ($urandom_range(0, 3) != 0);
        end
        if (mode == 5 && chars.size() > 1) begin
            split = $urandom_range(1, chars.size() - 1);
            send_run(chars, 0, split - 1, rg, 1'b1, 1'b0);
            cfg_write(tmr_pkg::REG_MIN_REPEATS, 64'($urandom_range(1, 3)));
            send_run(chars, split, chars.size() - 1, rg, 1'b0, 1'b1);
        end else begin
            send_run(chars, 0, chars.size() - 1, rg, with_first, with_last);
        end
    endtask

    task automatic test_random_regions();
        int unsigned target;
        int phase;
        target = chars_sent + 400;
        phase = 0;
        while (chars_sent < target) begin
            randomize_config(phase);
            repeat ($urandom_range(3, 8)) send_random_region();
            phase++;
        end
    endtask

    initial begin
        clear_scan_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_regions();
        drain_verdicts();
        $display("Sent %0d characters in %0d regions under %0d random register settings.",
                 chars_sent, regions_closed, settings_applied);
        $display("Checked %0d verdicts, %0d of them found a tandem repeat.",
                 verdicts_checked, verdicts_found);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d verdicts outstanding.", pending_verdicts.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
